### hdl/rti_pkg.sv
// Shared types and constants for the ray/triangle intersection unit.
`timescale 1ns / 1ps

package rti_pkg;

    // Coordinate word and fraction width (signed Q16.16)
    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;
    localparam int DIR_W   = FRAC_W + 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z = 3'd5;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
    } t_tri;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] hit_x;
        logic signed [COORD_W-1:0] hit_y;
        logic signed [COORD_W-1:0] hit_z;
    } t_res;

endpackage

### hdl/rti_mul.sv
// Two-stage signed multiplier split into partial products on the B operand.
`timescale 1ns / 1ps

module rti_mul #(
    parameter int AW = 33,
    parameter int BW = 52
) (
    input  logic                 i_clk,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [AW+BW-1:0] o_p
);

    localparam int SPLIT = BW / 2;

    logic signed [AW+SPLIT:0]      r_pl;
    logic signed [AW+BW-SPLIT-1:0] r_ph;
    logic signed [AW+BW-1:0]       r_p;

    // low half taken unsigned, high half carries the sign
    always_ff @(posedge i_clk) begin
        r_pl <= i_a * $signed({1'b0, i_b[SPLIT-1:0]});
        r_ph <= i_a * $signed(i_b[BW-1:SPLIT]);
        r_p  <= $signed({r_ph, {SPLIT{1'b0}}}) + (AW+BW)'(r_pl);
    end

    assign o_p = r_p;

endmodule

### hdl/rti_frac_div.sv
// Pipelined restoring divider: two numerators over one shared divisor, one bit a stage.
`timescale 1ns / 1ps

module rti_frac_div #(
    parameter int NW = 88,
    parameter int FB = 16
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_nu,
    input  logic [NW-1:0] i_nv,
    input  logic [NW-1:0] i_d,
    output logic [FB:0]   o_qu,
    output logic [FB:0]   o_qv
);

    logic [NW-1:0] r_nu [FB+1];
    logic [NW-1:0] r_nv [FB+1];
    logic [NW-1:0] r_d  [FB+1];
    logic [FB:0]   r_qu [FB+1];
    logic [FB:0]   r_qv [FB+1];

    // integer bit: set when the numerator is at least the divisor
    always_ff @(posedge i_clk) begin
        r_d[0]  <= i_d;
        r_nu[0] <= (i_nu >= i_d) ? i_nu - i_d : i_nu;
        r_nv[0] <= (i_nv >= i_d) ? i_nv - i_d : i_nv;
        r_qu[0] <= {{FB{1'b0}}, (i_nu >= i_d)};
        r_qv[0] <= {{FB{1'b0}}, (i_nv >= i_d)};
    end

    for (genvar k = 1; k <= FB; k++) begin : g_step
        logic [NW:0] w_su;
        logic [NW:0] w_sv;
        logic [NW:0] w_dx;
        logic        w_geu;
        logic        w_gev;

        assign w_su  = {r_nu[k-1], 1'b0};
        assign w_sv  = {r_nv[k-1], 1'b0};
        assign w_dx  = {1'b0, r_d[k-1]};
        assign w_geu = (w_su >= w_dx);
        assign w_gev = (w_sv >= w_dx);

        always_ff @(posedge i_clk) begin
            r_d[k]  <= r_d[k-1];
            r_nu[k] <= w_geu ? NW'(w_su - w_dx) : w_su[NW-1:0];
            r_nv[k] <= w_gev ? NW'(w_sv - w_dx) : w_sv[NW-1:0];
            r_qu[k] <= {r_qu[k-1][FB-1:0], w_geu};
            r_qv[k] <= {r_qv[k-1][FB-1:0], w_gev};
        end
    end

    assign o_qu = r_qu[FB];
    assign o_qv = r_qv[FB];

endmodule

### hdl/ray_triangle_intersect_unit.sv
// Top level: pipelined two-sided ray/triangle intersection with pick point output.
`timescale 1ns / 1ps
//
//  channel | ports                               | handshake
//  --------+-------------------------------------+--------------------------------
//  input   | i_start, o_busy, i_tri              | taken when i_start && !o_busy
//  result  | o_done, o_res                       | one-cycle strobe, no back-pressure
//  config  | i_cfg_we, i_cfg_idx, i_cfg_data     | write when i_cfg_we is high
//
//  One triangle enters every cycle; o_busy is always low.
//  Results leave in the order their triangles entered, in signed Q16.16;
//  the restoring divider, one quotient bit a stage, sets most of the pipeline depth.
//  Reset (synchronous, active low) clears valid bits and loads the ray
//  registers: origin zero, direction +z.
//  Nothing stalls: the receiver takes every word on its strobe cycle.

module ray_triangle_intersect_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  rti_pkg::t_tri         i_tri,
    output logic                  o_done,
    output rti_pkg::t_res         o_res,
    input  logic                  i_cfg_we,
    input  logic [rti_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [((rti_pkg::COORD_W > rti_pkg::DIR_W) ? rti_pkg::COORD_W
                                                       : rti_pkg::DIR_W)-1:0] i_cfg_data
);

    localparam int W   = rti_pkg::COORD_W;
    localparam int F   = rti_pkg::FRAC_W;
    localparam int DW  = rti_pkg::DIR_W;
    localparam int EW  = W + 1;            // edge / origin offset
    localparam int PW  = DW + EW + 1;      // p = dir x e2
    localparam int QW  = 2 * EW + 1;       // q = t x e1
    localparam int XW  = EW + PW + 3;      // det, u, v with sign fold headroom
    localparam int LW  = XW + 3 * F + 1;   // parallel limit compare width
    localparam int KD  = 11 + F;           // stage holding the weights
    localparam int LAT = KD + 3;           // accept to strobe
    localparam int NS  = KD + 1;           // side line depth
    localparam int NH  = F + 4;            // hit line depth
    localparam int SW  = EW + 4;           // pick point before saturation
    localparam int MW  = EW + F + 2;       // edge times weight

    localparam logic [LW-1:0] LIM = (LW'(1) << (3 * F)) / 10000;

    // cross product operand order: r[i] = x[I0]*y[J0] - x[I1]*y[J1]
    localparam int XI [6] = '{1, 2, 2, 0, 0, 1};
    localparam int XJ [6] = '{2, 1, 0, 2, 1, 0};

    // ------------------------------------------------------------------
    // ray registers
    // ------------------------------------------------------------------
    logic signed [W-1:0]  r_org [3];
    logic signed [DW-1:0] r_dir [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_dir[0] <= '0;
            r_dir[1] <= '0;
            r_dir[2] <= DW'(1) << F;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rti_pkg::CFG_ORG_X: r_org[0] <= i_cfg_data[W-1:0];
                rti_pkg::CFG_ORG_Y: r_org[1] <= i_cfg_data[W-1:0];
                rti_pkg::CFG_ORG_Z: r_org[2] <= i_cfg_data[W-1:0];
                rti_pkg::CFG_DIR_X: r_dir[0] <= i_cfg_data[DW-1:0];
                rti_pkg::CFG_DIR_Y: r_dir[1] <= i_cfg_data[DW-1:0];
                rti_pkg::CFG_DIR_Z: r_dir[2] <= i_cfg_data[DW-1:0];
                default: ;  // drop writes past the last register
            endcase
        end
    end

    // ------------------------------------------------------------------
    // valid line, one bit per stage
    // ------------------------------------------------------------------
    logic        w_take;
    logic [LAT-1:0] r_vld;

    assign w_take = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_take};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: edges, origin offset; side line carries a, e1, e2
    // ------------------------------------------------------------------
    logic signed [W-1:0]  w_a [3];
    logic signed [W-1:0]  w_b [3];
    logic signed [W-1:0]  w_c [3];
    logic signed [W-1:0]  r_sa  [NS][3];
    logic signed [EW-1:0] r_se1 [NS][3];
    logic signed [EW-1:0] r_se2 [NS][3];
    logic signed [EW-1:0] r1_t0 [3];

    assign w_a[0] = i_tri.a_x;
    assign w_a[1] = i_tri.a_y;
    assign w_a[2] = i_tri.a_z;
    assign w_b[0] = i_tri.b_x;
    assign w_b[1] = i_tri.b_y;
    assign w_b[2] = i_tri.b_z;
    assign w_c[0] = i_tri.c_x;
    assign w_c[1] = i_tri.c_y;
    assign w_c[2] = i_tri.c_z;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_sa[0][i]  <= w_a[i];
            r_se1[0][i] <= EW'(w_b[i]) - EW'(w_a[i]);
            r_se2[0][i] <= EW'(w_c[i]) - EW'(w_a[i]);
            // front-facing offset; a back face negates u and v later
            r1_t0[i]    <= EW'(r_org[i]) - EW'(w_a[i]);
        end
        for (int j = 1; j < NS; j++) begin
            r_sa[j]  <= r_sa[j-1];
            r_se1[j] <= r_se1[j-1];
            r_se2[j] <= r_se2[j-1];
        end
    end

    // ------------------------------------------------------------------
    // stages 2-3: p = dir x e2
    // ------------------------------------------------------------------
    logic signed [DW+EW-1:0] r2_pp [6];
    logic signed [EW-1:0]    r2_t0 [3];
    logic signed [PW-1:0]    r3_p  [3];
    logic signed [EW-1:0]    r3_t0 [3];

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 6; j++) begin
            r2_pp[j] <= r_dir[XI[j]] * r_se2[0][XJ[j]];
        end
        r2_t0 <= r1_t0;
        for (int i = 0; i < 3; i++) begin
            r3_p[i] <= PW'(r2_pp[2*i]) - PW'(r2_pp[2*i+1]);
        end
        r3_t0 <= r2_t0;
    end

    // ------------------------------------------------------------------
    // stages 4-5: det, u and q products (split multipliers)
    // ------------------------------------------------------------------
    logic signed [EW+PW-1:0] w_mdet [3];
    logic signed [EW+PW-1:0] w_mu   [3];
    logic signed [2*EW-1:0]  w_mq   [6];

    for (genvar i = 0; i < 3; i++) begin : g_dot
        rti_mul #(.AW(EW), .BW(PW)) u_mdet (
            .i_clk (i_clk),
            .i_a   (r_se1[2][i]),
            .i_b   (r3_p[i]),
            .o_p   (w_mdet[i])
        );
        rti_mul #(.AW(EW), .BW(PW)) u_mu (
            .i_clk (i_clk),
            .i_a   (r3_t0[i]),
            .i_b   (r3_p[i]),
            .o_p   (w_mu[i])
        );
    end

    for (genvar j = 0; j < 6; j++) begin : g_qcross
        rti_mul #(.AW(EW), .BW(EW)) u_mq (
            .i_clk (i_clk),
            .i_a   (r3_t0[XI[j]]),
            .i_b   (r_se1[2][XJ[j]]),
            .o_p   (w_mq[j])
        );
    end

    // ------------------------------------------------------------------
    // stage 6: sum det and u, finish q
    // ------------------------------------------------------------------
    logic signed [XW-1:0] r6_det;
    logic signed [XW-1:0] r6_u;
    logic signed [QW-1:0] r6_q [3];

    always_ff @(posedge i_clk) begin
        r6_det <= XW'(w_mdet[0]) + XW'(w_mdet[1]) + XW'(w_mdet[2]);
        r6_u   <= XW'(w_mu[0]) + XW'(w_mu[1]) + XW'(w_mu[2]);
        for (int i = 0; i < 3; i++) begin
            r6_q[i] <= QW'(w_mq[2*i]) - QW'(w_mq[2*i+1]);
        end
    end

    // ------------------------------------------------------------------
    // stages 7-8: v products; fold back faces to a positive det
    // ------------------------------------------------------------------
    logic signed [DW+QW-1:0] w_mv [3];
    logic                    r7_neg;
    logic signed [XW-1:0]    r7_dabs;
    logic signed [XW-1:0]    r7_u;
    logic                    r8_neg;
    logic signed [XW-1:0]    r8_dabs;
    logic signed [XW-1:0]    r8_u;

    for (genvar i = 0; i < 3; i++) begin : g_vdot
        rti_mul #(.AW(DW), .BW(QW)) u_mv (
            .i_clk (i_clk),
            .i_a   (r_dir[i]),
            .i_b   (r6_q[i]),
            .o_p   (w_mv[i])
        );
    end

    always_ff @(posedge i_clk) begin
        r7_neg  <= !(r6_det > 0);
        r7_dabs <= (r6_det > 0) ? r6_det : -r6_det;
        r7_u    <= (r6_det > 0) ? r6_u : -r6_u;
        r8_neg  <= r7_neg;
        r8_dabs <= r7_dabs;
        r8_u    <= r7_u;
    end

    // ------------------------------------------------------------------
    // stage 9: v; stage 10: range checks
    // ------------------------------------------------------------------
    logic signed [XW-1:0] w_vsum;
    logic signed [XW-1:0] r9_v;
    logic signed [XW-1:0] r9_dabs;
    logic signed [XW-1:0] r9_u;
    logic signed [XW:0]   w_uv;
    logic                 w_hit;
    logic                 r10_hit;
    logic [XW-1:0]        r10_dabs;
    logic [XW-1:0]        r10_u;
    logic [XW-1:0]        r10_v;

    assign w_vsum = XW'(w_mv[0]) + XW'(w_mv[1]) + XW'(w_mv[2]);
    assign w_uv   = (XW+1)'(r9_u) + (XW+1)'(r9_v);

    // reject near-parallel rays, then require 0 <= u, 0 <= v, u + v <= det
    assign w_hit = !(LW'($unsigned(r9_dabs)) < LIM)
                && !r9_u[XW-1]
                && !(r9_dabs < r9_u)
                && !r9_v[XW-1]
                && !((XW+1)'(r9_dabs) < w_uv);

    always_ff @(posedge i_clk) begin
        r9_v     <= r8_neg ? -w_vsum : w_vsum;
        r9_dabs  <= r8_dabs;
        r9_u     <= r8_u;
        r10_hit  <= w_hit;
        r10_dabs <= r9_dabs;
        r10_u    <= r9_u;
        r10_v    <= r9_v;
    end

    // ------------------------------------------------------------------
    // stages 11..KD: barycentric weights
    // ------------------------------------------------------------------
    logic [F:0] w_wu;
    logic [F:0] w_wv;
    logic       r_hit [NH];

    rti_frac_div #(.NW(XW), .FB(F)) u_div (
        .i_clk (i_clk),
        .i_nu  (r10_u),
        .i_nv  (r10_v),
        .i_d   (r10_dabs),
        .o_qu  (w_wu),
        .o_qv  (w_wv)
    );

    always_ff @(posedge i_clk) begin
        r_hit[0] <= w_hit;
        for (int j = 1; j < NH; j++) begin
            r_hit[j] <= r_hit[j-1];
        end
    end

    // ------------------------------------------------------------------
    // pick point: weight products, sum and shift, saturate
    // ------------------------------------------------------------------
    logic signed [MW-1:0]   r_m1 [3];
    logic signed [MW-1:0]   r_m2 [3];
    logic signed [MW:0]     w_ms [3];
    logic signed [SW-1:0]   r_s  [3];
    logic signed [W-1:0]    w_sat [3];
    rti_pkg::t_res          r_out;

    for (genvar i = 0; i < 3; i++) begin : g_pick
        assign w_ms[i] = (MW+1)'(r_m1[i]) + (MW+1)'(r_m2[i]);
        // clamp when the bits above the sign disagree
        assign w_sat[i] = (r_s[i][SW-1:W-1] == {(SW-W+1){r_s[i][SW-1]}})
                        ? r_s[i][W-1:0]
                        : (r_s[i][SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_m1[i] <= r_se1[KD-1][i] * $signed({1'b0, w_wu});
            r_m2[i] <= r_se2[KD-1][i] * $signed({1'b0, w_wv});
            r_s[i]  <= SW'(w_ms[i] >>> F) + SW'(r_sa[KD][i]);
        end
        r_out.hit   <= r_hit[NH-1];
        r_out.hit_x <= r_hit[NH-1] ? w_sat[0] : '0;
        r_out.hit_y <= r_hit[NH-1] ? w_sat[1] : '0;
        r_out.hit_z <= r_hit[NH-1] ? w_sat[2] : '0;
    end

    assign o_busy = 1'b0;
    assign o_done = r_vld[LAT-1];
    assign o_res  = r_out;

`ifndef ASSERT_OFF
    // every accepted triangle is followed by its o_done strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> ##LAT o_done)
        else $error("result strobe missing after accepted triangle");

    // a miss carries a zero pick point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_res.hit) |-> (o_res.hit_x == '0 && o_res.hit_y == '0
                                    && o_res.hit_z == '0))
        else $error("miss with nonzero pick point");

    // an accepted hit never divides by a zero determinant
    a_det_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[9] && r10_hit) |-> (r10_dabs != '0))
        else $error("hit with zero determinant");
`endif

endmodule
